FILE: rtl/rrd_pkg.sv
// Package with shared types and constants of the record deframer.
`timescale 1ns / 1ps
package rrd_pkg;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_BYTE     = 2'd1,
    CMD_CANCEL   = 2'd2,
    CMD_FAIL     = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_CONSUMED   = 4'd0,
    ST_REGISTERED = 4'd1,
    ST_FULL       = 4'd2,
    ST_MATCHED    = 4'd3,
    ST_UNMATCHED  = 4'd4,
    ST_SHORT      = 4'd5,
    ST_FAILED     = 4'd6,
    ST_CANCELLED  = 4'd7,
    ST_NOT_FOUND  = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_EXEC = 2'd1,
    FSM_OUT  = 2'd2
  } fsm_e;

  localparam logic [2:0] XID_BYTES = 3'd4;

  typedef struct packed {
    logic execute;
  } ctrl_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] req_xid;
    logic [7:0]  data_byte;
    logic [7:0]  fail_code;
  } in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [3:0]  slot;
    logic [31:0] reply_xid;
    logic [15:0] failed_mask;
    logic [7:0]  error_out;
    logic [4:0]  pending_count;
  } out_t;

endpackage

FILE: rtl/rrd_stream_if.sv
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
interface rrd_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/rrd_ctrl.sv
// Controller: sequences one transaction through execute and output.
`timescale 1ns / 1ps
module rrd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rrd_pkg::ctrl_t ctrl_o
);
  rrd_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= rrd_pkg::FSM_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rrd_pkg::FSM_IDLE: if (in_valid_i) state_d = rrd_pkg::FSM_EXEC;
      rrd_pkg::FSM_EXEC: state_d = rrd_pkg::FSM_OUT;
      rrd_pkg::FSM_OUT:  if (out_ready_i) state_d = rrd_pkg::FSM_IDLE;
      default:           state_d = rrd_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    ctrl_o.execute = 1'b0;
    case (state_q)
      rrd_pkg::FSM_IDLE: in_ready_o = 1'b1;
      rrd_pkg::FSM_EXEC: ctrl_o.execute = 1'b1;
      rrd_pkg::FSM_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule

FILE: rtl/rrd_datapath.sv
// Datapath: framing registers, pending table and result register.
`timescale 1ns / 1ps
module rrd_datapath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_take_i,
  input  rrd_pkg::in_t   in_i,
  input  rrd_pkg::ctrl_t ctrl_i,
  output rrd_pkg::out_t  out_o
);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int MW = (TABLE_DEPTH < 16) ? TABLE_DEPTH : 16;

  rrd_pkg::in_t in_q;
  logic in_body_q, in_body_d, last_q, last_d;
  logic [1:0] mcnt_q, mcnt_d;
  logic [23:0] mshift_q, mshift_d;
  logic [30:0] left_q, left_d;
  logic [2:0] seen_q, seen_d;
  logic [31:0] cxid_q, cxid_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [31:0] xid_q [TABLE_DEPTH];
  logic [CW-1:0] cnt_q, cnt_d;
  rrd_pkg::out_t res_q, res_d;

  logic [TABLE_DEPTH-1:0] hit, freev;
  logic [31:0] key;
  logic [31:0] cxid_next;
  logic [IW-1:0] hit_idx, free_idx;
  logic hit_any, free_any, wr_en;
  logic [31:0] hdr;

  // Captured XID including the current body byte, used for the lookup.
  assign cxid_next = (seen_q < rrd_pkg::XID_BYTES) ? {cxid_q[23:0], in_q.data_byte} : cxid_q;
  assign key = (in_q.command == rrd_pkg::CMD_CANCEL) ? in_q.req_xid : cxid_next;

  always_comb begin
    hit_idx = '0; free_idx = '0; hit_any = 1'b0; free_any = 1'b0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      hit[i] = valid_q[i] && (xid_q[i] == key);
      freev[i] = !valid_q[i];
      if (hit[i]) begin hit_any = 1'b1; hit_idx = IW'(i); end
      if (freev[i]) begin free_any = 1'b1; free_idx = IW'(i); end
    end
  end

  always_comb begin
    in_body_d = in_body_q; last_d = last_q; mcnt_d = mcnt_q; mshift_d = mshift_q;
    left_d = left_q; seen_d = seen_q; cxid_d = cxid_q; valid_d = valid_q;
    cnt_d = cnt_q; wr_en = 1'b0;
    res_d = '0;
    res_d.status = rrd_pkg::ST_CONSUMED;
    hdr = {mshift_q, in_q.data_byte};
    case (in_q.command)
      rrd_pkg::CMD_REGISTER: begin
        if (free_any) begin
          valid_d[free_idx] = 1'b1; wr_en = 1'b1; cnt_d = cnt_q + 1'b1;
          res_d.status = rrd_pkg::ST_REGISTERED;
          res_d.slot = 4'(free_idx);
        end else res_d.status = rrd_pkg::ST_FULL;
      end
      rrd_pkg::CMD_BYTE: begin
        if (!in_body_q) begin
          if (mcnt_q != 2'd3) begin
            mshift_d = {mshift_q[15:0], in_q.data_byte};
            mcnt_d = mcnt_q + 2'd1;
          end else begin
            mcnt_d = '0; mshift_d = '0;
            if (hdr[30:0] != '0) begin
              left_d = hdr[30:0]; last_d = hdr[31]; in_body_d = 1'b1;
            end
          end
        end else begin
          if (seen_q < rrd_pkg::XID_BYTES) begin
            cxid_d = cxid_next;
            seen_d = seen_q + 3'd1;
          end
          left_d = left_q - 31'd1;
          if (left_d == '0) begin
            in_body_d = 1'b0;
            if (last_q) begin
              if (seen_d < rrd_pkg::XID_BYTES) res_d.status = rrd_pkg::ST_SHORT;
              else begin
                res_d.reply_xid = cxid_d;
                if (hit_any) begin
                  valid_d[hit_idx] = 1'b0; cnt_d = cnt_q - 1'b1;
                  res_d.status = rrd_pkg::ST_MATCHED;
                  res_d.slot = 4'(hit_idx);
                end else res_d.status = rrd_pkg::ST_UNMATCHED;
              end
              seen_d = '0; cxid_d = '0; last_d = 1'b0;
            end
          end
        end
      end
      rrd_pkg::CMD_CANCEL: begin
        if (hit_any) begin
          valid_d[hit_idx] = 1'b0; cnt_d = cnt_q - 1'b1;
          res_d.status = rrd_pkg::ST_CANCELLED;
          res_d.slot = 4'(hit_idx);
        end else res_d.status = rrd_pkg::ST_NOT_FOUND;
      end
      default: begin
        res_d.failed_mask = 16'(valid_q[MW-1:0]);
        res_d.status = rrd_pkg::ST_FAILED;
        res_d.error_out = in_q.fail_code;
        valid_d = '0; cnt_d = '0;
        in_body_d = 1'b0; last_d = 1'b0; mcnt_d = '0; mshift_d = '0;
        left_d = '0; seen_d = '0; cxid_d = '0;
      end
    endcase
    res_d.pending_count = 5'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q <= 1'b0; last_q <= 1'b0; mcnt_q <= '0; mshift_q <= '0;
      left_q <= '0; seen_q <= '0; cxid_q <= '0; valid_q <= '0; cnt_q <= '0;
    end else if (ctrl_i.execute) begin
      in_body_q <= in_body_d; last_q <= last_d; mcnt_q <= mcnt_d;
      mshift_q <= mshift_d; left_q <= left_d; seen_q <= seen_d;
      cxid_q <= cxid_d; valid_q <= valid_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take_i) in_q <= in_i;
    if (ctrl_i.execute) begin
      res_q <= res_d;
      if (wr_en) xid_q[free_idx] <= in_q.req_xid;
    end
  end

  assign out_o = res_q;
endmodule

FILE: rtl/rpc_record_deframer_xid_match.sv
// Top level of the RPC record deframer with pending XID matching.
// The input channel carries one transaction per command: register a pending
// XID, push one reply stream byte, cancel an XID, or fail the connection.
// Every accepted input transaction yields exactly one result transaction on
// the output channel with status, slot, reply XID, failed mask, error number
// and the pending count after the command.
// Each transaction passes through accept, execute, and offering the result;
// the next input is accepted once the result has been taken. The execute cycle
// holds the parallel XID compare across all table slots and the framing update.
// The block thus works on one transaction at a time, even with a ready sink.
// Reset empties the pending table and returns framing to waiting for a record
// mark; no clearing pass is needed. When the receiver stalls, the result is
// held stable and no further input is accepted until it is taken.
`timescale 1ns / 1ps
module rpc_record_deframer_xid_match #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  rrd_stream_if.sink   in_i,
  rrd_stream_if.source out_o
);
  rrd_pkg::ctrl_t ctrl;
  logic in_ready;
  rrd_pkg::out_t res;

  rrd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_ready),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .ctrl_o(ctrl)
  );

  rrd_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk_i, .rst_ni,
    .in_take_i(in_i.valid && in_ready),
    .in_i(in_i.data), .ctrl_i(ctrl), .out_o(res)
  );

  assign in_i.ready = in_ready;
  assign out_o.data = res;
endmodule
